// ----- src/adc_pkg.sv -----
`default_nettype none

package adc_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_0       = 3'd3;

  // Widest table the result mask can describe
  localparam int MASK_W = 4;

  // Prefix modes
  localparam logic PREFIX_FIXED = 1'b0;
  localparam logic PREFIX_ZTERM = 1'b1;

  // One attribute table entry, packed as written on the config port
  typedef struct packed {
    logic        optional;
    logic [15:0] maxlen;
    logic [7:0]  id;
  } entry_t;

  // Table lookup result for the held id
  typedef struct packed {
    logic              hit;
    logic [MASK_W-1:0] sel;
    logic [15:0]       maxlen;
    logic [MASK_W-1:0] req_mask;
  } match_t;

  // Per-frame verdict
  typedef struct packed {
    logic              complete;
    logic              malformed;
    logic [MASK_W-1:0] found_mask;
  } result_t;

endpackage

`default_nettype wire

// ----- src/adc_in_if.sv -----
`default_nettype none

interface adc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- src/adc_out_if.sv -----
`default_nettype none

interface adc_out_if;
  logic                      valid;
  logic                      ready;
  logic                      complete;
  logic                      malformed;
  logic [adc_pkg::MASK_W-1:0] found_mask;

  modport source (output valid, output complete, output malformed, output found_mask,
                  input ready);
  modport sink   (input valid, input complete, input malformed, input found_mask,
                  output ready);
endinterface

`default_nettype wire

// ----- src/adc_cfg_if.sv -----
`default_nettype none

interface adc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [adc_pkg::CFG_IDX_W-1:0]  index;
  logic [adc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/adc_match.sv -----
`default_nettype none

// Parallel id compare against the table; lowest matching entry wins.
module adc_match #(
  parameter int TABLE_ENTRIES = 4
) (
  input  wire adc_pkg::entry_t [TABLE_ENTRIES-1:0] entries,
  input  wire logic [2:0]                          entry_count,
  input  wire logic [7:0]                          held_id,
  output adc_pkg::match_t                          match
);

  logic [TABLE_ENTRIES-1:0] in_use;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      in_use[i] = (3'(i) < entry_count);
    end
  end

  always_comb begin
    match = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (in_use[i] && !entries[i].optional) begin
        match.req_mask[i] = 1'b1;
      end
      if (in_use[i] && (entries[i].id == held_id)) begin
        match.hit    = 1'b1;
        match.sel    = '0;
        match.sel[i] = 1'b1;
        match.maxlen = entries[i].maxlen;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/adc_parse.sv -----
`default_nettype none

// Frame parse state and per-byte update; verdict formed from the next state.
module adc_parse (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      frame_byte,
  input  wire logic            frame_end,
  input  wire logic            prefix_mode,
  input  wire logic [7:0]      header_length,
  input  wire adc_pkg::match_t match,
  output logic [7:0]           held_id,
  output adc_pkg::result_t     result
);

  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_ID     = 6'b000010,
    PH_LEN_LO = 6'b000100,
    PH_LEN_HI = 6'b001000,
    PH_VALUE  = 6'b010000,
    PH_STOP   = 6'b100000
  } phase_t;

  phase_t                     phase_r, phase_nxt, eff_phase;
  logic [7:0]                 byte_cnt_r, byte_cnt_nxt;
  logic [15:0]                remain_r, remain_nxt;
  logic [7:0]                 held_id_r, held_id_nxt;
  logic [7:0]                 len_lo_r, len_lo_nxt;
  logic [adc_pkg::MASK_W-1:0] seen_r, seen_nxt;
  logic                       err_r, err_nxt;
  logic [1:0]                 attr_cnt_r, attr_cnt_nxt;
  logic                       attr;
  logic [15:0]                len;
  logic                       ok;

  assign held_id = held_id_r;
  assign len     = {frame_byte, len_lo_r};

  always_comb begin
    phase_nxt    = phase_r;
    byte_cnt_nxt = byte_cnt_r;
    remain_nxt   = remain_r;
    held_id_nxt  = held_id_r;
    len_lo_nxt   = len_lo_r;
    seen_nxt     = seen_r;
    err_nxt      = err_r;
    attr_cnt_nxt = attr_cnt_r;
    attr         = 1'b0;
    eff_phase    = phase_r;

    if (phase_r == PH_PREFIX) begin
      if (prefix_mode == adc_pkg::PREFIX_FIXED) begin
        if (byte_cnt_r < header_length) begin
          byte_cnt_nxt = 8'(byte_cnt_r + 8'd1);
        end else begin
          // header done: this byte is already the first id
          attr      = 1'b1;
          eff_phase = PH_ID;
        end
      end else if (frame_byte == 8'd0) begin
        phase_nxt = PH_ID;
      end
    end else begin
      attr = 1'b1;
    end

    if (attr) begin
      if (attr_cnt_r != 2'd3) begin
        attr_cnt_nxt = 2'(attr_cnt_r + 2'd1);
      end
      unique case (eff_phase)
        PH_ID: begin
          held_id_nxt = frame_byte;
          phase_nxt   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo_nxt = frame_byte;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (!match.hit || ((match.maxlen != 16'd0) && (len > match.maxlen))) begin
            err_nxt   = 1'b1;
            phase_nxt = PH_STOP;
          end else begin
            seen_nxt   = seen_r | match.sel;
            remain_nxt = len;
            phase_nxt  = (len != 16'd0) ? PH_VALUE : PH_ID;
          end
        end
        PH_VALUE: begin
          remain_nxt = 16'(remain_r - 16'd1);
          if (remain_nxt == 16'd0) begin
            phase_nxt = PH_ID;
          end
        end
        default: begin
          // stopped after an error: drop the rest of the frame
        end
      endcase
    end
  end

  always_comb begin
    ok     = ((match.req_mask & ~seen_nxt) == '0) && (phase_nxt != PH_VALUE);
    result = '0;
    if (attr_cnt_nxt == 2'd0) begin
      result = '0;
    end else if (attr_cnt_nxt != 2'd3) begin
      result.malformed = 1'b1;
    end else if (err_nxt) begin
      result.malformed  = 1'b1;
      result.found_mask = seen_nxt;
    end else begin
      result.complete   = ok;
      result.found_mask = seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && frame_end)) begin
      phase_r    <= PH_PREFIX;
      byte_cnt_r <= '0;
      remain_r   <= '0;
      held_id_r  <= '0;
      len_lo_r   <= '0;
      seen_r     <= '0;
      err_r      <= 1'b0;
      attr_cnt_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      remain_r   <= remain_nxt;
      held_id_r  <= held_id_nxt;
      len_lo_r   <= len_lo_nxt;
      seen_r     <= seen_nxt;
      err_r      <= err_nxt;
      attr_cnt_r <= attr_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/ancs_attribute_dict_checker_core.sv -----
// Pipeline: a frame_end input transaction passes the input register, then the result register,
// which holds the result until the sink takes it.
// Throughput: one byte per cycle; a byte without frame_end moves on even while a result waits.
// Only a frame_end byte stalls, and only when the result register is still held by the sink.
// Reset: synchronous, active low; parse state goes to prefix, table and header length to
// their reset values, both pipeline registers empty.
`default_nettype none

module ancs_attribute_dict_checker_core #(
  parameter int TABLE_ENTRIES = 4
) (
  input wire logic  clk,
  input wire logic  rst_n,
  adc_in_if.sink    in_chan,
  adc_out_if.source out_chan,
  adc_cfg_if.sink   cfg_chan
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are taken every cycle; an index past the
  // table is dropped.
  // ---------------------------------------------------------------------------
  logic                                     prefix_mode_r;
  logic [7:0]                               header_length_r;
  logic [2:0]                               entry_count_r;
  adc_pkg::entry_t [TABLE_ENTRIES-1:0]      entries_r;
  logic                                     cfg_we;

  assign cfg_chan.ready = 1'b1;
  assign cfg_we         = cfg_chan.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_mode_r   <= adc_pkg::PREFIX_FIXED;
      header_length_r <= 8'd5;
      entry_count_r   <= '0;
      entries_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_chan.index)
        adc_pkg::REG_PREFIX_MODE:   prefix_mode_r   <= cfg_chan.data[0];
        adc_pkg::REG_HEADER_LENGTH: header_length_r <= cfg_chan.data[7:0];
        adc_pkg::REG_ENTRY_COUNT:   entry_count_r   <= cfg_chan.data[2:0];
        default: begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (cfg_chan.index == adc_pkg::CFG_IDX_W'(adc_pkg::REG_ENTRY_0 + i)) begin
              entries_r[i] <= cfg_chan.data;
            end
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. The byte in it is consumed (s1_fire) whenever it carries no
  // frame end, or the result register is free or being drained this cycle.
  // ---------------------------------------------------------------------------
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       s1_fire;
  logic       in_take;
  logic       out_valid_r;

  adc_pkg::result_t out_data_r;
  adc_pkg::result_t result;
  adc_pkg::match_t  match;
  logic [7:0]       held_id;

  assign s1_fire       = s1_valid_r && (!s1_end_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_chan.frame_byte;
      s1_end_r  <= in_chan.frame_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Table compare on the held id, and the per-byte parse update.
  // ---------------------------------------------------------------------------
  adc_match #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_match (
    .entries     (entries_r),
    .entry_count (entry_count_r),
    .held_id     (held_id),
    .match       (match)
  );

  adc_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_fire),
    .frame_byte    (s1_byte_r),
    .frame_end     (s1_end_r),
    .prefix_mode   (prefix_mode_r),
    .header_length (header_length_r),
    .match         (match),
    .held_id       (held_id),
    .result        (result)
  );

  // ---------------------------------------------------------------------------
  // Result register: loaded by the frame_end byte, held until the sink takes it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_end_r) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.complete   = out_data_r.complete;
  assign out_chan.malformed  = out_data_r.malformed;
  assign out_chan.found_mask = out_data_r.found_mask;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_from_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_end_r))
    else $error("result appeared without a frame_end byte");

  a_stalled_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_end_r)))
    else $error("stalled input byte lost");

  a_verdict_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.complete && out_data_r.malformed))
    else $error("frame reported both complete and malformed");

endmodule

`default_nettype wire
